FILE: rtl/mdbc_pkg.sv
`default_nettype none

package mdbc_pkg;

  // Default PWM full-scale value.
  localparam int PWM_MAX_DEF = 255;

  // Number of valid ADC bits in a battery sample.
  localparam int ADC_BITS = 10;

  localparam int BATT_W  = 10;
  localparam int REF_W   = 10;
  localparam int POWER_W = 16;
  localparam int DUTY_W  = 8;

  // Clamped power magnitude runs 0..PCT_LIMIT.
  localparam int PCT_LIMIT = 100;
  localparam int PCT_W     = $clog2(PCT_LIMIT + 1);

  localparam logic signed [POWER_W-1:0] PCT_MIN = -16'sd100;
  localparam logic signed [POWER_W-1:0] PCT_MAX = 16'sd100;

  localparam logic [REF_W-1:0]  REF_RESET = 10'd497;
  localparam logic [BATT_W-1:0] ADC_MASK  = BATT_W'((32'd1 << ADC_BITS) - 32'd1);

  // Action codes.
  localparam logic ACT_DRIVE = 1'b0;
  localparam logic ACT_BRAKE = 1'b1;

  // Status codes.
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_MOTOR = 1'b1;

  // Enable pin modes.
  localparam logic [1:0] EN_LOW  = 2'd0;
  localparam logic [1:0] EN_PWM  = 2'd1;
  localparam logic [1:0] EN_HIGH = 2'd2;

  typedef struct packed {
    logic                      action;
    logic [1:0]                motor_index;
    logic signed [POWER_W-1:0] power_percent;
    logic [BATT_W-1:0]         battery_reading;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic              motor_select;
    logic              direction_update;
    logic              pin_a_level;
    logic              pin_b_level;
    logic [1:0]        enable_mode;
    logic [DUTY_W-1:0] duty;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/motor_drive_battery_compensated_top.sv
// Motor drive command block with battery voltage compensation.
// Command words arrive on in_word under in_valid/in_stall and are taken at a
// clock edge where in_valid is high and in_stall is low. Each command gives
// exactly one result word on out_word under out_valid/out_stall, in order.
// The reference battery reading is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while no command is in flight (the block does not enforce this).
// A command first passes a classifying front stage, then a two-entry queue,
// then the back end: a multiply stage, one restoring divider stage per
// quotient bit, and an output register. One command is accepted each cycle
// while in_stall is low, and the divider pipeline takes a new word each
// cycle unless the stages ahead of it are stalled.
// A synchronous reset empties every stage and the queue and loads the
// reference reading with 497. When the receiver stalls, the output word
// holds, the back end fills up, the queue absorbs the front stage, and only
// then is in_stall raised.
`default_nettype none

module motor_drive_battery_compensated_top #(
  parameter int PWM_MAX = mdbc_pkg::PWM_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [mdbc_pkg::REF_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire mdbc_pkg::cmd_t             in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output mdbc_pkg::res_t                  out_word
);

  localparam int MW = $clog2(PWM_MAX + 1);
  localparam int DW = mdbc_pkg::BATT_W;
  localparam int QDW = $bits(mdbc_pkg::res_t) + MW + DW + 1;

  // Reference battery reading; the user must write it only while the block is idle, the block does not enforce this.
  logic [mdbc_pkg::REF_W-1:0] ref_reading;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_reading <= mdbc_pkg::REF_RESET;
    end else if (cfg_wr_en) begin
      ref_reading <= cfg_wr_data;
    end
  end

  logic           in_ready;
  logic           f_valid;
  logic           f_ready;
  mdbc_pkg::res_t f_res;
  logic [MW-1:0]  f_mag;
  logic [DW-1:0]  f_div;
  logic           f_zdiv;

  logic           q_valid;
  logic           q_ready;
  logic [QDW-1:0] q_data;
  mdbc_pkg::res_t q_res;
  logic [MW-1:0]  q_mag;
  logic [DW-1:0]  q_div;
  logic           q_zdiv;

  assign in_stall = !in_ready;

  mdbc_front #(
    .PWM_MAX(PWM_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .ref_reading(ref_reading),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_word),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_res    (f_res),
    .out_mag    (f_mag),
    .out_div    (f_div),
    .out_zdiv   (f_zdiv)
  );

  // The queue lets the front keep accepting while the back end is stalled.
  mdbc_queue #(
    .W(QDW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  ({f_res, f_mag, f_div, f_zdiv}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  assign {q_res, q_mag, q_div, q_zdiv} = q_data;

  mdbc_back #(
    .PWM_MAX(PWM_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ref_reading(ref_reading),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_res     (q_res),
    .in_mag     (q_mag),
    .in_div     (q_div),
    .in_zdiv    (q_zdiv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

FILE: rtl/mdbc_front.sv
`default_nettype none

module mdbc_front #(
  parameter int PWM_MAX = mdbc_pkg::PWM_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [mdbc_pkg::REF_W-1:0]   ref_reading,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire mdbc_pkg::cmd_t               in_cmd,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output mdbc_pkg::res_t                    out_res,
  output logic [$clog2(PWM_MAX+1)-1:0]      out_mag,
  output logic [mdbc_pkg::BATT_W-1:0]       out_div,
  output logic                              out_zdiv
);

  localparam int MW = $clog2(PWM_MAX + 1);

  // Scaled magnitude for every clamped percentage, fixed at elaboration.
  logic [MW-1:0] mag_tbl [0:mdbc_pkg::PCT_LIMIT];

  for (genvar g = 0; g <= mdbc_pkg::PCT_LIMIT; g++) begin : g_tbl
    assign mag_tbl[g] = MW'(g * PWM_MAX / mdbc_pkg::PCT_LIMIT);
  end

  logic [mdbc_pkg::PCT_W-1:0]  pct;
  logic [MW-1:0]               mag;
  logic                        neg;
  logic [mdbc_pkg::BATT_W-1:0] batt;
  logic [mdbc_pkg::BATT_W-1:0] div;
  mdbc_pkg::res_t              res;
  logic [MW-1:0]               res_mag;

  always_comb begin
    priority if (in_cmd.power_percent < mdbc_pkg::PCT_MIN) begin
      pct = mdbc_pkg::PCT_W'(mdbc_pkg::PCT_LIMIT);
    end else if (in_cmd.power_percent > mdbc_pkg::PCT_MAX) begin
      pct = mdbc_pkg::PCT_W'(mdbc_pkg::PCT_LIMIT);
    end else if (in_cmd.power_percent < 0) begin
      pct = mdbc_pkg::PCT_W'(-in_cmd.power_percent);
    end else begin
      pct = mdbc_pkg::PCT_W'(in_cmd.power_percent);
    end
  end

  assign mag = mag_tbl[pct];
  // A request that scales to zero counts as forward.
  assign neg = (in_cmd.power_percent < 0) && (mag != '0);

  // A sagging reading below half the reference is treated as nominal.
  assign batt = in_cmd.battery_reading & mdbc_pkg::ADC_MASK;
  assign div  = (batt < (ref_reading >> 1)) ? ref_reading : batt;

  always_comb begin
    res     = '0;
    res_mag = '0;
    priority if (in_cmd.motor_index[1]) begin
      res.status = mdbc_pkg::ST_BAD_MOTOR;
    end else if (in_cmd.action == mdbc_pkg::ACT_BRAKE) begin
      res.motor_select     = in_cmd.motor_index[0];
      res.direction_update = 1'b1;
      res.pin_a_level      = 1'b1;
      res.pin_b_level      = 1'b1;
      res.enable_mode      = mdbc_pkg::EN_HIGH;
    end else if (in_cmd.power_percent == '0) begin
      res.motor_select = in_cmd.motor_index[0];
    end else begin
      res.motor_select     = in_cmd.motor_index[0];
      res.direction_update = 1'b1;
      res.pin_a_level      = !neg;
      res.pin_b_level      = neg;
      res.enable_mode      = mdbc_pkg::EN_PWM;
      res_mag              = mag;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res  <= res;
      out_mag  <= res_mag;
      out_div  <= div;
      out_zdiv <= (div == '0);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mdbc_queue.sv
`default_nettype none

module mdbc_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mdbc_back.sv
`default_nettype none

module mdbc_back #(
  parameter int PWM_MAX = mdbc_pkg::PWM_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mdbc_pkg::REF_W-1:0]    ref_reading,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mdbc_pkg::res_t                in_res,
  input  wire logic [$clog2(PWM_MAX+1)-1:0]  in_mag,
  input  wire logic [mdbc_pkg::BATT_W-1:0]   in_div,
  input  wire logic                          in_zdiv,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mdbc_pkg::res_t                     out_word
);

  localparam int MW = $clog2(PWM_MAX + 1);
  // The divisor is never below half the reference, so the quotient is at
  // most three times the magnitude.
  localparam int QW = $clog2(3 * PWM_MAX + 1);
  localparam int NW = mdbc_pkg::REF_W + MW;
  localparam int DW = mdbc_pkg::BATT_W;

  logic           v        [0:QW];
  logic           rdy      [0:QW];
  mdbc_pkg::res_t sres     [0:QW];
  logic [DW-1:0]  srem     [0:QW];
  logic [QW-1:0]  squo     [0:QW];
  logic [DW-1:0]  sdiv     [0:QW];
  logic           sovr     [0:QW];
  logic           sovr_val [0:QW];

  logic          out_rdy;
  logic [NW-1:0] num;
  logic [QW-1:0] sat;
  mdbc_pkg::res_t fmt;

  assign out_rdy  = !out_valid || !out_stall;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < QW; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign rdy[QW] = !v[QW] || out_rdy;

  // Stage 0: numerator product, split into the leading partial remainder and
  // the bits still to be shifted in.
  assign num = NW'(ref_reading) * NW'(in_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      sres[0]     <= in_res;
      srem[0]     <= DW'(num >> QW);
      squo[0]     <= num[QW-1:0];
      sdiv[0]     <= in_div;
      sovr[0]     <= in_zdiv;
      sovr_val[0] <= (num != '0);
    end
  end

  // One restoring division step per stage.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DW:0] trial;
    logic        ge;

    assign trial = {srem[k-1], squo[k-1][QW-1]};
    assign ge    = (trial >= {1'b0, sdiv[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v[k-1]) begin
        sres[k]     <= sres[k-1];
        srem[k]     <= ge ? DW'(trial - {1'b0, sdiv[k-1]}) : trial[DW-1:0];
        squo[k]     <= {squo[k-1][QW-2:0], ge};
        sdiv[k]     <= sdiv[k-1];
        sovr[k]     <= sovr[k-1];
        sovr_val[k] <= sovr_val[k-1];
      end
    end
  end

  always_comb begin
    priority if (sovr[QW]) begin
      sat = sovr_val[QW] ? QW'(PWM_MAX) : '0;
    end else if (squo[QW] > QW'(PWM_MAX)) begin
      sat = QW'(PWM_MAX);
    end else begin
      sat = squo[QW];
    end
    fmt      = sres[QW];
    fmt.duty = (sres[QW].enable_mode == mdbc_pkg::EN_PWM) ? mdbc_pkg::DUTY_W'(sat) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_rdy) begin
      out_valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && v[QW]) begin
      out_word <= fmt;
    end
  end

endmodule

`default_nettype wire
